### sv/vrt_pkg.sv
`timescale 1ns / 1ps
package vrt_pkg;
	localparam int GridBits = 5;
	localparam int FracBits = 8;
	localparam int OrgW = GridBits + FracBits;
	localparam int TW = FracBits + 16;
	localparam int DistW = 14;
	localparam int MapAw = 3 * GridBits;
	localparam int CellW = GridBits + 4;
	localparam int NumW = 15 + FracBits;
	localparam int DivSteps = NumW;
	localparam int DivCntW = $clog2(DivSteps + 1);
	localparam logic [DistW-1:0] MaxDistReset = DistW'(2560);
	localparam logic [TW-1:0] TSat = {TW{1'b1}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_DIV,
		ST_READ,
		ST_TEST,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clear_step;
		logic load;
		logic div_start;
		logic div_step;
		logic read;
		logic advance;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic div_done;
		logic solid;
		logic below;
	} stat_t;
endpackage

### sv/voxel_ray_traversal_top.sv
`timescale 1ns / 1ps
// voxel ray walk over a 32x32x32 one-bit solid map
// items enter on start while busy is low; mode 0 writes one voxel, mode 1 casts
// a write item gives no result
// a cast runs bit-serial division, six dividers side by side,
// then for each voxel tested a map read, then a test and step,
// then a done state registers the result; result appears on the cycle
// after with done high for exactly one cycle
// busy is low again in the done cycle, so the next item can be taken then
// max_distance is written through cfg_we and cfg_wdata; the user must do so
// only while idle, which the block does not enforce; after reset the map is
// cleared one voxel a cycle with busy high; max_distance resets to 10.0
// the receiver cannot stall; each result is shown once
module voxel_ray_traversal_top (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic cfg_we,
	input  logic [13:0] cfg_wdata,
	input  logic mode,
	input  logic [vrt_pkg::GridBits-1:0] voxel_x,
	input  logic [vrt_pkg::GridBits-1:0] voxel_y,
	input  logic [vrt_pkg::GridBits-1:0] voxel_z,
	input  logic solid,
	input  logic [vrt_pkg::OrgW-1:0] origin_x,
	input  logic [vrt_pkg::OrgW-1:0] origin_y,
	input  logic [vrt_pkg::OrgW-1:0] origin_z,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	input  logic signed [15:0] dir_z,
	output logic done,
	output logic hit,
	output logic [vrt_pkg::GridBits-1:0] hit_x,
	output logic [vrt_pkg::GridBits-1:0] hit_y,
	output logic [vrt_pkg::GridBits-1:0] hit_z,
	output logic signed [1:0] normal_x,
	output logic signed [1:0] normal_y,
	output logic signed [1:0] normal_z,
	output logic [13:0] hit_distance
);
	import vrt_pkg::*;

	cmd_t cmd;
	stat_t st;
	logic accept;

	assign accept = start && !busy;

	vrt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .accept(accept), .mode(mode),
		.st(st), .cmd(cmd), .busy(busy)
	);

	vrt_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .mode(mode),
		.voxel_x(voxel_x), .voxel_y(voxel_y), .voxel_z(voxel_z), .solid(solid),
		.origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
		.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
		.done(done), .hit(hit), .hit_x(hit_x), .hit_y(hit_y), .hit_z(hit_z),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.hit_distance(hit_distance)
	);

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_step |-> busy)
		else $error("accept during map clear");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result held two cycles");
	a_cast_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode) |=> busy)
		else $error("cast did not raise busy");
endmodule

### sv/vrt_ctrl.sv
`timescale 1ns / 1ps
module vrt_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  logic mode,
	input  vrt_pkg::stat_t st,
	output vrt_pkg::cmd_t cmd,
	output logic busy
);
	import vrt_pkg::*;

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_n;
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_CLEAR: if (st.clear_done) state_n = ST_IDLE;
			ST_IDLE: if (accept && mode) state_n = ST_DIV;
			ST_DIV: if (st.div_done) state_n = ST_READ;
			ST_READ: state_n = ST_TEST;
			ST_TEST: begin
				if (!st.below || st.solid) state_n = ST_DONE;
				else state_n = ST_READ;
			end
			ST_DONE: state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			ST_CLEAR: cmd.clear_step = 1'b1;
			ST_IDLE: begin
				busy = 1'b0;
				cmd.load = accept;
				cmd.div_start = accept && mode;
			end
			ST_DIV: cmd.div_step = 1'b1;
			ST_READ: cmd.read = 1'b1;
			ST_TEST: cmd.advance = st.below && !st.solid;
			ST_DONE: cmd.finish = 1'b1;
			default: busy = 1'b1;
		endcase
	end
endmodule

### sv/vrt_dp.sv
`timescale 1ns / 1ps
module vrt_dp (
	input  logic clk,
	input  logic arst_n,
	input  vrt_pkg::cmd_t cmd,
	output vrt_pkg::stat_t st,
	input  logic cfg_we,
	input  logic [13:0] cfg_wdata,
	input  logic mode,
	input  logic [vrt_pkg::GridBits-1:0] voxel_x,
	input  logic [vrt_pkg::GridBits-1:0] voxel_y,
	input  logic [vrt_pkg::GridBits-1:0] voxel_z,
	input  logic solid,
	input  logic [vrt_pkg::OrgW-1:0] origin_x,
	input  logic [vrt_pkg::OrgW-1:0] origin_y,
	input  logic [vrt_pkg::OrgW-1:0] origin_z,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	input  logic signed [15:0] dir_z,
	output logic done,
	output logic hit,
	output logic [vrt_pkg::GridBits-1:0] hit_x,
	output logic [vrt_pkg::GridBits-1:0] hit_y,
	output logic [vrt_pkg::GridBits-1:0] hit_z,
	output logic signed [1:0] normal_x,
	output logic signed [1:0] normal_y,
	output logic signed [1:0] normal_z,
	output logic [13:0] hit_distance
);
	import vrt_pkg::*;

	logic map_q [2**MapAw];
	logic [MapAw:0] clr_q;
	logic [DistW-1:0] limit_q;
	logic rd_q;

	logic signed [CellW-1:0] cell_q [3];
	logic [1:0] stp_q [3];
	logic [TW-1:0] tm_q [3];
	logic [TW-1:0] td_q [3];
	logic [NumW-1:0] num_q [6];
	logic [NumW-1:0] rem_q [6];
	logic [NumW-1:0] quo_q [6];
	logic [15:0] mag_q [3];
	logic [DivCntW-1:0] dcnt_q;
	logic [TW-1:0] dist_q;
	logic [1:0] nrm_q [3];
	logic dist_fin_q;

	logic [OrgW-1:0] org [3];
	logic [15:0] dir [3];
	assign org[0] = origin_x;
	assign org[1] = origin_y;
	assign org[2] = origin_z;
	assign dir[0] = dir_x;
	assign dir[1] = dir_y;
	assign dir[2] = dir_z;

	logic [1:0] sel;
	logic [TW:0] tsum;
	logic inside_grid;
	logic [MapAw-1:0] rd_addr, wr_addr;

	always_comb begin
		if (tm_q[0] < tm_q[1] && tm_q[0] < tm_q[2]) sel = 2'd0;
		else if (tm_q[1] < tm_q[2]) sel = 2'd1;
		else sel = 2'd2;
		tsum = {1'b0, tm_q[sel]} + {1'b0, td_q[sel]};
		inside_grid = 1'b1;
		for (int a = 0; a < 3; a++)
			if (cell_q[a] < 0 || cell_q[a] >= CellW'(2**GridBits)) inside_grid = 1'b0;
		rd_addr = {cell_q[0][GridBits-1:0], cell_q[1][GridBits-1:0],
			cell_q[2][GridBits-1:0]};
		wr_addr = cmd.clear_step ? clr_q[MapAw-1:0] : {voxel_x, voxel_y, voxel_z};
	end

	assign st.clear_done = clr_q[MapAw];
	assign st.div_done = (dcnt_q == DivCntW'(DivSteps));
	assign st.solid = rd_q && inside_grid;
	assign st.below = !dist_fin_q && (dist_q < TW'(limit_q));

	always_ff @(posedge clk) begin
		if (cmd.clear_step) map_q[wr_addr] <= 1'b0;
		else if (cmd.load && !mode) map_q[wr_addr] <= solid;
		if (cmd.read) rd_q <= map_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			limit_q <= MaxDistReset;
			dcnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= cmd.finish;
			if (cmd.clear_step && !clr_q[MapAw]) clr_q <= clr_q + 1'b1;
			if (cfg_we) limit_q <= cfg_wdata;
			if (cmd.div_start) dcnt_q <= '0;
			else if (cmd.div_step && !st.div_done) dcnt_q <= dcnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dist_q <= '0;
			dist_fin_q <= 1'b0;
			for (int a = 0; a < 3; a++) begin
				logic neg;
				logic [15:0] m;
				logic [FracBits:0] fr;
				neg = dir[a][15];
				m = neg ? 16'(17'h10000 - {1'b0, dir[a]}) : dir[a];
				fr = neg ? {1'b0, org[a][FracBits-1:0]}
					: (FracBits+1)'(2**FracBits) - {1'b0, org[a][FracBits-1:0]};
				mag_q[a] <= m;
				cell_q[a] <= CellW'(org[a][OrgW-1:FracBits]);
				stp_q[a] <= (m == 0) ? 2'b00 : (neg ? 2'b11 : 2'b01);
				num_q[a] <= NumW'(fr) << 14;
				num_q[a+3] <= NumW'(1) << (14 + FracBits);
				rem_q[a] <= '0;
				rem_q[a+3] <= '0;
				nrm_q[a] <= 2'b00;
			end
		end else if (cmd.div_step && !st.div_done) begin
			for (int k = 0; k < 6; k++) begin
				logic [NumW:0] r;
				r = {rem_q[k], num_q[k][NumW-1]};
				num_q[k] <= {num_q[k][NumW-2:0], 1'b0};
				if (r >= (NumW+1)'(mag_q[k % 3])) begin
					rem_q[k] <= NumW'(r - (NumW+1)'(mag_q[k % 3]));
					quo_q[k] <= {quo_q[k][NumW-2:0], 1'b1};
				end else begin
					rem_q[k] <= NumW'(r);
					quo_q[k] <= {quo_q[k][NumW-2:0], 1'b0};
				end
			end
		end else if (cmd.div_step) begin
			for (int a = 0; a < 3; a++) begin
				if (mag_q[a] == 0) begin
					tm_q[a] <= TSat;
					td_q[a] <= TSat;
				end else begin
					tm_q[a] <= (quo_q[a] > NumW'(TSat)) ? TSat : TW'(quo_q[a]);
					td_q[a] <= (quo_q[a+3] > NumW'(TSat)) ? TSat : TW'(quo_q[a+3]);
				end
			end
		end else if (cmd.advance) begin
			dist_q <= tm_q[sel];
			tm_q[sel] <= tsum[TW] ? TSat : tsum[TW-1:0];
			cell_q[sel] <= cell_q[sel] + CellW'(signed'(stp_q[sel]));
			for (int a = 0; a < 3; a++)
				nrm_q[a] <= (sel == 2'(a)) ? 2'(-signed'(stp_q[a])) : 2'b00;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			hit <= st.solid && st.below;
			hit_x <= st.solid && st.below ? cell_q[0][GridBits-1:0] : '0;
			hit_y <= st.solid && st.below ? cell_q[1][GridBits-1:0] : '0;
			hit_z <= st.solid && st.below ? cell_q[2][GridBits-1:0] : '0;
			normal_x <= st.solid && st.below ? nrm_q[0] : '0;
			normal_y <= st.solid && st.below ? nrm_q[1] : '0;
			normal_z <= st.solid && st.below ? nrm_q[2] : '0;
			hit_distance <= st.solid && st.below ? dist_q[DistW-1:0] : '0;
		end
	end
endmodule

### sim/vrt_checker.sv
`timescale 1ns / 1ps
module vrt_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  logic cfg_we,
	input  logic [13:0] cfg_wdata,
	input  logic mode,
	input  logic [vrt_pkg::GridBits-1:0] voxel_x,
	input  logic [vrt_pkg::GridBits-1:0] voxel_y,
	input  logic [vrt_pkg::GridBits-1:0] voxel_z,
	input  logic solid,
	input  logic [vrt_pkg::OrgW-1:0] origin_x,
	input  logic [vrt_pkg::OrgW-1:0] origin_y,
	input  logic [vrt_pkg::OrgW-1:0] origin_z,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	input  logic signed [15:0] dir_z,
	input  logic done,
	input  logic hit,
	input  logic [vrt_pkg::GridBits-1:0] hit_x,
	input  logic [vrt_pkg::GridBits-1:0] hit_y,
	input  logic [vrt_pkg::GridBits-1:0] hit_z,
	input  logic signed [1:0] normal_x,
	input  logic signed [1:0] normal_y,
	input  logic signed [1:0] normal_z,
	input  logic [13:0] hit_distance,
	output int errors,
	output int pending,
	output int n_casts,
	output int n_hits
);
	import vrt_pkg::*;

	localparam int Cells = 1 << MapAw;
	localparam longint TSatL = (64'd1 << TW) - 1;

	typedef struct packed {
		logic hit;
		logic [GridBits-1:0] x;
		logic [GridBits-1:0] y;
		logic [GridBits-1:0] z;
		logic [1:0] nx;
		logic [1:0] ny;
		logic [1:0] nz;
		logic [DistW-1:0] hd;
	} ray_res_t;

	bit solid_map [Cells];
	logic [DistW-1:0] max_dist;
	ray_res_t hit_q[$];

	function automatic longint sat(longint v);
		return (v > TSatL) ? TSatL : v;
	endfunction

	function automatic bit map_at(int x, int y, int z);
		if (x < 0 || y < 0 || z < 0 || x >= 32 || y >= 32 || z >= 32)
			return 0;
		return solid_map[(x << 10) | (y << 5) | z];
	endfunction

	function automatic ray_res_t trace_ray(logic [OrgW-1:0] o [3], logic [15:0] d [3]);
		ray_res_t r;
		int vc [3];
		int stp [3];
		longint tmax [3];
		longint tdel [3];
		longint frac, mag, t_cur;
		int a;
		r = '0;
		t_cur = 0;
		for (int i = 0; i < 3; i++) begin
			frac = o[i][FracBits-1:0];
			mag = d[i][15] ? (65536 - longint'(d[i])) : longint'(d[i]);
			vc[i] = int'(o[i] >> FracBits);
			if (mag == 0) begin
				stp[i] = 0;
				tmax[i] = TSatL;
				tdel[i] = TSatL;
			end else begin
				tdel[i] = sat((64'd1 << (14 + FracBits)) / mag);
				if (d[i][15]) begin
					stp[i] = -1;
					tmax[i] = sat((frac << 14) / mag);
				end else begin
					stp[i] = 1;
					tmax[i] = sat((((64'd1 << FracBits) - frac) << 14) / mag);
				end
			end
		end
		while (t_cur < longint'(max_dist)) begin
			if (map_at(vc[0], vc[1], vc[2])) begin
				r.hit = 1;
				r.x = vc[0][GridBits-1:0];
				r.y = vc[1][GridBits-1:0];
				r.z = vc[2][GridBits-1:0];
				r.hd = t_cur[DistW-1:0];
				return r;
			end
			if (tmax[0] < tmax[1] && tmax[0] < tmax[2])
				a = 0;
			else if (tmax[1] < tmax[2])
				a = 1;
			else
				a = 2;
			t_cur = tmax[a];
			tmax[a] = sat(tmax[a] + tdel[a]);
			vc[a] += stp[a];
			r.nx = '0;
			r.ny = '0;
			r.nz = '0;
			case (a)
				0: r.nx = (stp[a] > 0) ? 2'b11 : 2'b01;
				1: r.ny = (stp[a] > 0) ? 2'b11 : 2'b01;
				default: r.nz = (stp[a] > 0) ? 2'b11 : 2'b01;
			endcase
		end
		return '0;
	endfunction

	assign pending = hit_q.size();

	always @(posedge clk or negedge arst_n) begin
		ray_res_t want, got;
		logic [OrgW-1:0] org [3];
		logic [15:0] dv [3];
		if (!arst_n) begin
			foreach (solid_map[i])
				solid_map[i] = 0;
			max_dist <= MaxDistReset;
			errors <= 0;
			n_casts <= 0;
			n_hits <= 0;
			hit_q.delete();
		end else begin
			if (cfg_we)
				max_dist <= cfg_wdata;
			if (start && !busy) begin
				if (!mode) begin
					solid_map[{voxel_x, voxel_y, voxel_z}] = solid;
				end else begin
					org[0] = origin_x;
					org[1] = origin_y;
					org[2] = origin_z;
					dv[0] = dir_x;
					dv[1] = dir_y;
					dv[2] = dir_z;
					want = trace_ray(org, dv);
					hit_q.push_back(want);
					n_casts <= n_casts + 1;
					if (want.hit)
						n_hits <= n_hits + 1;
				end
			end
			if (done) begin
				got = '{hit, hit_x, hit_y, hit_z, normal_x, normal_y, normal_z, hit_distance};
				if (hit_q.size() == 0) begin
					if (errors < 10)
						$display("%0t: result with nothing expected: %p", $time, got);
					errors <= errors + 1;
				end else begin
					want = hit_q.pop_front();
					if (got.hit !== want.hit || got.x !== want.x || got.y !== want.y ||
					    got.z !== want.z || got.nx !== want.nx || got.ny !== want.ny ||
					    got.nz !== want.nz || got.hd !== want.hd) begin
						if (errors < 10)
							$display("%0t: mismatch exp %p act %p", $time, want, got);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import vrt_pkg::*;

	localparam int CycleLimit = 3000000;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic cfg_we = 0;
	logic [13:0] cfg_wdata = '0;
	logic mode = 0;
	logic [GridBits-1:0] voxel_x = '0, voxel_y = '0, voxel_z = '0;
	logic solid = 0;
	logic [OrgW-1:0] origin_x = '0, origin_y = '0, origin_z = '0;
	logic signed [15:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic done, hit;
	logic [GridBits-1:0] hit_x, hit_y, hit_z;
	logic signed [1:0] normal_x, normal_y, normal_z;
	logic [13:0] hit_distance;
	int errors, pending, n_casts, n_hits;
	int cycles = 0;
	int idle_pct = 0;
	int n_items = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	voxel_ray_traversal_top dut (.*);

	vrt_checker u_chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send(input logic m, input logic [14:0] vox, input logic s,
	                    input logic [OrgW-1:0] ox, oy, oz, input logic [15:0] dx, dy, dz);
		start <= 1;
		mode <= m;
		{voxel_x, voxel_y, voxel_z} <= vox;
		solid <= s;
		origin_x <= ox;
		origin_y <= oy;
		origin_z <= oz;
		dir_x <= dx;
		dir_y <= dy;
		dir_z <= dz;
		do @(posedge clk); while (busy);
		n_items++;
		if ($urandom_range(99) < idle_pct) begin
			start <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic put_voxel(input int x, y, z, s);
		send(1'b0, {x[4:0], y[4:0], z[4:0]}, 1'(s), OrgW'($urandom), OrgW'($urandom),
		     OrgW'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	task automatic cast(input int ox, oy, oz, dx, dy, dz);
		send(1'b1, 15'($urandom), 1'($urandom), OrgW'(ox), OrgW'(oy), OrgW'(oz),
		     16'(dx), 16'(dy), 16'(dz));
	endtask

	task automatic settle();
		start <= 0;
		@(posedge clk);
		while (pending != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_limit(input logic [13:0] v);
		settle();
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// aimed at a dense box in the middle of the grid so that most casts hit
	task automatic random_item();
		int ox, oy, oz, vx, vy, vz, big;
		if ($urandom_range(99) < 35) begin
			if ($urandom_range(3) == 0)
				put_voxel($urandom_range(31), $urandom_range(31), $urandom_range(31),
				          $urandom_range(1));
			else
				put_voxel($urandom_range(12, 19), $urandom_range(12, 19),
				          $urandom_range(12, 19), int'($urandom_range(99) < 30));
			return;
		end
		ox = $urandom_range(8191);
		oy = $urandom_range(8191);
		oz = $urandom_range(8191);
		if ($urandom_range(9) == 0) begin
			cast(ox, oy, oz, $urandom, $urandom, $urandom);
			return;
		end
		vx = 4096 - ox + $urandom_range(1024) - 512;
		vy = 4096 - oy + $urandom_range(1024) - 512;
		vz = 4096 - oz + $urandom_range(1024) - 512;
		big = (vx < 0) ? -vx : vx;
		if ((vy < 0 ? -vy : vy) > big) big = (vy < 0) ? -vy : vy;
		if ((vz < 0 ? -vz : vz) > big) big = (vz < 0) ? -vz : vz;
		if (big == 0) big = 1;
		vx = vx * 16384 / big;
		vy = vy * 16384 / big;
		vz = vz * 16384 / big;
		if ($urandom_range(7) == 0) vx = 0;
		if ($urandom_range(7) == 0) vy = 0;
		cast(ox, oy, oz, vx, vy, vz);
	endtask

	task automatic run_random(input int count, input int pct);
		idle_pct = pct;
		repeat (count) random_item();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		// directed: corners, origin inside a solid voxel, ties, zero and extreme directions
		put_voxel(0, 0, 0, 1);
		put_voxel(31, 31, 31, 1);
		put_voxel(5, 5, 5, 1);
		cast(0, 0, 0, 16384, 0, 0);
		cast('h1f80, 'h1f80, 'h1f80, 16384, 16384, 16384);
		cast(8191, 8191, 8191, 16384, 16384, 16384);
		cast('h0380, 'h0580, 'h0580, 16384, 0, 0);
		cast('h0600, 'h0580, 'h0580, -16384, 0, 0);
		cast('h0400, 'h0400, 'h0400, 9459, 9459, 9459);
		cast('h0680, 'h0680, 'h0680, -9459, -9459, -9459);
		cast('h0580, 'h0580, 'h0300, 0, 0, 16384);
		cast('h0200, 'h0200, 'h0200, 0, 0, 0);
		cast('h0100, 'h0100, 'h0100, 'h8000, 'h7fff, 'h8000);
		cast('h0580, 'h0580, 'h0680, 'h7fff, 'h8000, 'h8000);
		cast('h1555, 'h0aaa, 'h1fff, -16384, -16384, -16384);
		put_voxel(5, 5, 5, 0);
		cast('h0380, 'h0580, 'h0580, 16384, 0, 0);
		put_voxel(0, 0, 0, 0);
		cast('h0080, 'h0080, 'h0080, -16384, 0, 0);
		set_limit(14'd0);
		cast(0, 0, 0, 16384, 16384, 16384);
		cast('h1f80, 'h1f80, 'h1f80, 16384, 0, 0);
		run_random(40, 24);
		set_limit(14'd16383);
		run_random(330, 24);
		set_limit(14'($urandom_range(256, 16383)));
		run_random(330, 86);
		set_limit(14'd2560);
		run_random(330, 0);
		settle();
		repeat (50) @(posedge clk);
		$display("%0d items sent, %0d casts of which %0d hit, limits 0, 2560, 16383 and random",
		         n_items, n_casts, n_hits);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
